// ===== src/stable_sorted_priority_queue_core_defines.svh =====
// Assertion macros for the stable sorted priority queue core.
// Used by stable_sorted_priority_queue_core.sv; expects clk_i and rst_ni in scope.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// check outside reset only
`define SSPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every edge, reset included
`define SSPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/sspq_pkg.sv =====
// Shared types and constants of the stable sorted priority queue.
// No dependencies; used by the core, sspq_step and the testbench.
package sspq_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned PAYLOAD_BITS  = 16;
  localparam int unsigned IDX_W         = $clog2(DEPTH);
  localparam int unsigned CNT_W         = $clog2(DEPTH + 1);
  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned OCC_W         = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] priority_val;
  } entry_t;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [PAYLOAD_BITS-1:0]  payload;
    logic [PRIORITY_BITS-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic                     out_valid;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [PRIORITY_BITS-1:0] out_priority;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     now_empty;
  } out_word_t;

  typedef struct packed {
    logic             later;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] idx_dec;
    logic [IDX_W-1:0] idx_dec2;
    logic [CNT_W-1:0] idx_next;
  } step_t;

endpackage

// ===== src/stable_sorted_priority_queue_core.sv =====
// Top level of the stable sorted priority queue: sequencer, entry RAM, step unit.
// Depends on sspq_pkg, sspq_ram, sspq_step and the core defines header.
//
//   channel | signals                            | word
//   in      | in_valid_i, in_ready_o, in_word_i  | func, payload, priority_req
//   out     | out_valid_o, out_ready_i, out_word_o | removed entry, status, occupancy
//
// Insert: one RAM slot moved per cycle until the new entry's place is found.
// Remove: the RAM read port moves one slot per cycle.
// Clear, dropped or rejected words go straight to S_FIN and move no RAM slots.
// Reset empties the queue at once; RAM contents are left as they are.
// A result waits in the output register; the sequencer holds its last step while it is full.
`include "stable_sorted_priority_queue_core_defines.svh"
module stable_sorted_priority_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sspq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sspq_pkg::out_word_t out_word_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_REM  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [sspq_pkg::CNT_W-1:0]    count_q, count_d;
  logic [sspq_pkg::IDX_W-1:0]    k_q, k_d;
  sspq_pkg::entry_t              req_q, req_d;
  logic                          res_valid_q, res_valid_d;
  sspq_pkg::entry_t              res_q, res_d;
  sspq_pkg::status_e             res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  sspq_pkg::out_word_t           out_word_q, out_word_d;

  logic                          accept;
  logic [sspq_pkg::IDX_W-1:0]    step_idx;
  sspq_pkg::step_t               step;
  logic                          we;
  logic [sspq_pkg::IDX_W-1:0]    waddr;
  sspq_pkg::entry_t              wdata;
  logic [sspq_pkg::IDX_W-1:0]    raddr;
  sspq_pkg::entry_t              rdata;

  sspq_ram #(
    .WIDTH ($bits(sspq_pkg::entry_t)),
    .DEPTH (sspq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign step_idx = (state_q == S_IDLE) ? count_q[sspq_pkg::IDX_W-1:0] : k_q;

  sspq_step u_step (
    .idx_i     (step_idx),
    .rd_pri_i  (rdata.priority_val),
    .req_pri_i (req_q.priority_val),
    .step_o    (step)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    req_d        = req_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_word_d   = out_word_q;
    we           = 1'b0;
    waddr        = k_q;
    wdata        = req_q;
    raddr        = '0;
    case (state_q)
      S_IDLE: begin
        raddr = (in_word_i.func == sspq_pkg::FUNC_REMOVE) ? '0 : step.idx_dec;
        if (accept) begin
          req_d.payload      = in_word_i.payload;
          req_d.priority_val = in_word_i.priority_req;
          res_valid_d        = 1'b0;
          res_d              = '0;
          res_status_d       = sspq_pkg::ST_OK;
          state_d            = S_FIN;
          case (in_word_i.func)
            sspq_pkg::FUNC_INSERT: begin
              if (count_q == sspq_pkg::CNT_W'(sspq_pkg::DEPTH)) begin
                res_status_d = sspq_pkg::ST_FULL;
              end else begin
                k_d     = count_q[sspq_pkg::IDX_W-1:0];
                state_d = S_INS;
              end
            end
            sspq_pkg::FUNC_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = sspq_pkg::ST_EMPTY;
              end else begin
                k_d     = '0;
                state_d = S_REM;
              end
            end
            sspq_pkg::FUNC_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        raddr = step.idx_dec2;
        we    = 1'b1;
        waddr = k_q;
        if (k_q == '0 || !step.later) begin
          wdata   = req_q;
          count_d = count_q + sspq_pkg::CNT_W'(1);
          state_d = S_FIN;
        end else begin
          wdata = rdata;
          k_d   = step.idx_dec;
        end
      end
      S_REM: begin
        raddr = step.idx_inc;
        if (k_q == '0) begin
          res_valid_d = 1'b1;
          res_d       = rdata;
        end else begin
          we    = 1'b1;
          waddr = step.idx_dec;
          wdata = rdata;
        end
        if (step.idx_next == count_q) begin
          count_d = count_q - sspq_pkg::CNT_W'(1);
          state_d = S_FIN;
        end else begin
          k_d = step.idx_inc;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_word_d.out_valid    = res_valid_q;
          out_word_d.out_payload  = res_q.payload;
          out_word_d.out_priority = res_q.priority_val;
          out_word_d.status       = res_status_q;
          out_word_d.occupancy    = sspq_pkg::OCC_W'(count_q);
          out_word_d.now_empty    = (count_q == '0);
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    req_q        <= req_d;
    res_valid_q  <= res_valid_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
    out_word_q   <= out_word_d;
  end

  `SSPQ_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= sspq_pkg::CNT_W'(sspq_pkg::DEPTH), "count above depth")
  `SSPQ_ASSERT(a_count_step, count_q != $past(count_q) |-> count_q == $past(count_q) + sspq_pkg::CNT_W'(1) || count_q == $past(count_q) - sspq_pkg::CNT_W'(1) || count_q == '0, "count jumped")
  `SSPQ_ASSERT(a_full_occ, out_valid_o && out_word_o.status == sspq_pkg::ST_FULL |-> out_word_o.occupancy == sspq_pkg::OCC_W'(sspq_pkg::DEPTH), "drop without full queue")
  `SSPQ_ASSERT(a_fin_hold, state_q == S_FIN && out_valid_q && !out_ready_i |=> state_q == S_FIN, "result lost while output busy")

endmodule

// ===== src/sspq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sspq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/sspq_step.sv =====
// Shared step unit: priority compare and slot index arithmetic.
// Depends on sspq_pkg.
module sspq_step (
  input  logic [sspq_pkg::IDX_W-1:0]         idx_i,
  input  logic [sspq_pkg::PRIORITY_BITS-1:0] rd_pri_i,
  input  logic [sspq_pkg::PRIORITY_BITS-1:0] req_pri_i,
  output sspq_pkg::step_t                    step_o
);

  logic [sspq_pkg::CNT_W-1:0] next;

  assign next            = sspq_pkg::CNT_W'(idx_i) + sspq_pkg::CNT_W'(1);
  assign step_o.later    = rd_pri_i > req_pri_i;
  assign step_o.idx_next = next;
  assign step_o.idx_inc  = next[sspq_pkg::IDX_W-1:0];
  assign step_o.idx_dec  = idx_i - sspq_pkg::IDX_W'(1);
  assign step_o.idx_dec2 = idx_i - sspq_pkg::IDX_W'(2);

endmodule

// ===== tb/testbench.sv =====
// Testbench for stable_sorted_priority_queue_core: directed and random insert, remove,
// clear and unused-code words checked against a scoreboard that mirrors the sorted queue.
// Depends on sspq_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sspq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 2 * (DEPTH + 3);
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  class pq_scoreboard;
    entry_t    slots[DEPTH];
    int        held;
    out_word_t awaited[$];
    int        mismatches;
    int        checked;
    int        n_insert, n_dropped, n_remove, n_empty, n_clear, n_unused, peak;

    function new();
      held = 0;
      mismatches = 0;
      checked = 0;
      n_insert = 0; n_dropped = 0; n_remove = 0; n_empty = 0;
      n_clear = 0; n_unused = 0; peak = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_op(in_word_t w);
      out_word_t r;
      int        pos;
      r = '0;
      r.status = ST_OK;
      case (w.func)
        FUNC_INSERT: begin
          n_insert++;
          if (held >= DEPTH) begin
            r.status = ST_FULL;
            n_dropped++;
          end else begin
            pos = 0;
            while (pos < held && slots[pos].priority_val <= w.priority_req) pos++;
            for (int k = held; k > pos; k--) slots[k] = slots[k-1];
            slots[pos].payload = w.payload;
            slots[pos].priority_val = w.priority_req;
            held++;
          end
        end
        FUNC_REMOVE: begin
          n_remove++;
          if (held == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            r.out_valid = 1'b1;
            r.out_payload = slots[0].payload;
            r.out_priority = slots[0].priority_val;
            for (int k = 1; k < held; k++) slots[k-1] = slots[k];
            held--;
          end
        end
        FUNC_CLEAR: begin
          n_clear++;
          held = 0;
        end
        default: n_unused++;
      endcase
      if (held > peak) peak = held;
      r.occupancy = OCC_W'(held);
      r.now_empty = (held == 0);
      awaited.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word %h", got);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.out_valid !== want.out_valid || got.out_payload !== want.out_payload ||
          got.out_priority !== want.out_priority || got.status !== want.status ||
          got.occupancy !== want.occupancy || got.now_empty !== want.now_empty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected v=%0b pay=%h pri=%h st=%0d occ=%0d emp=%0b, got v=%0b pay=%h pri=%h st=%0d occ=%0d emp=%0b",
                   checked, want.out_valid, want.out_payload, want.out_priority,
                   want.status, want.occupancy, want.now_empty,
                   got.out_valid, got.out_payload, got.out_priority,
                   got.status, got.occupancy, got.now_empty);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  bit           gaps_on;
  bit           hold_request;
  int           cycle_count;
  pq_scoreboard sb;

  stable_sorted_priority_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("stable_sorted_priority_queue_core: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_op(in_word_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_word_o);
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(99) < 13);
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [PAYLOAD_BITS-1:0] pay,
                         input logic [PRIORITY_BITS-1:0] pri);
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i.func <= op;
    in_word_i.payload <= pay;
    in_word_i.priority_req <= pri;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int                       counted;
    int                       mode_left;
    int                       insert_pct;
    int                       roll;
    bit                       hold_done;
    logic [FUNC_W-1:0]        op;
    logic [PRIORITY_BITS-1:0] pri;

    sb = new();
    cycle_count = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty remove, extremes, ties, unused code, fill to full, drop, clear
    send_op(FUNC_REMOVE, 16'h0000, 8'h00);
    send_op(FUNC_INSERT, 16'hffff, 8'hff);
    send_op(FUNC_INSERT, 16'h0000, 8'h00);
    for (int i = 1; i <= 3; i++) send_op(FUNC_INSERT, PAYLOAD_BITS'(i), 8'd7);
    send_op(FUNC_UNUSED, 16'ha5a5, 8'h5a);
    send_op(FUNC_REMOVE, 16'h0000, 8'h00);
    send_op(FUNC_REMOVE, 16'h0000, 8'h00);
    for (int i = 0; i < 13; i++)
      send_op(FUNC_INSERT, 16'h8000 | PAYLOAD_BITS'(i),
              (i % 3 == 0) ? 8'd7 : (i % 3 == 1) ? 8'hff : 8'h00);
    send_op(FUNC_INSERT, 16'h1234, 8'h01);
    send_op(FUNC_CLEAR, 16'h0000, 8'h00);
    send_op(FUNC_REMOVE, 16'h0000, 8'h00);

    // random: phases biased toward filling, draining or balanced traffic
    counted = 0;
    mode_left = 0;
    insert_pct = 50;
    while (counted < RANDOM_WORDS) begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0: insert_pct = 75;
          1: insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      mode_left--;
      gaps_on = !(counted >= 500 && counted < 800);
      if (counted == 900 && !hold_done) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 1) op = FUNC_UNUSED;
      else if (roll < 3) op = FUNC_CLEAR;
      else if ($urandom_range(99) < insert_pct) op = FUNC_INSERT;
      else op = FUNC_REMOVE;
      roll = $urandom_range(99);
      if (roll < 40) pri = PRIORITY_BITS'($urandom_range(3));
      else if (roll < 50) pri = $urandom_range(1) ? 8'hff : 8'h00;
      else pri = PRIORITY_BITS'($urandom);
      send_op(op, PAYLOAD_BITS'($urandom), pri);
      if (op != FUNC_UNUSED) counted++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts (%0d dropped when full), %0d removes (%0d on empty), %0d clears, %0d unused codes",
             sb.n_insert, sb.n_dropped, sb.n_remove, sb.n_empty, sb.n_clear, sb.n_unused);
    $display("checked %0d result words, peak occupancy %0d, %0d mismatches",
             sb.checked, sb.peak, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("stable_sorted_priority_queue_core: match");
    end else begin
      $display("stable_sorted_priority_queue_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== stable_sorted_priority_queue_core.f =====
+incdir+src
src/sspq_pkg.sv
src/sspq_ram.sv
src/sspq_step.sv
src/stable_sorted_priority_queue_core.sv
tb/testbench.sv
